/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holding at an edge implies consequent at the same edge.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holding at an edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ngt_pkg.sv */
// ----------------------------------------------------------------------------
// ngt_pkg
// Shared types and codes of the next greater element table.
// ----------------------------------------------------------------------------
package ngt_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // answer when an entry has no greater element yet
   localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_P_STK,
      S_P_ELEM,
      S_P_FIN,
      S_Q_SCAN,
      S_Q_GRD,
      S_DONE
   } ngt_state_type;

   typedef struct packed {
      logic lt;   // a < b, signed
      logic eq;   // a == b
   } ngt_cmp_type;

endpackage

/* rtl/core/ngt_ram.sv */
// ----------------------------------------------------------------------------
// ngt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ngt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ngt_cmp.sv */
// ----------------------------------------------------------------------------
// ngt_cmp
// Shared compare unit: signed less-than and equality of two values.
// ----------------------------------------------------------------------------
module ngt_cmp
   import ngt_pkg::*;
(
   input  logic [VALUE_W-1:0] a,
   input  logic [VALUE_W-1:0] b,
   output ngt_cmp_type        result
);

   assign result.lt = $signed(a) < $signed(b);
   assign result.eq = (a == b);

endmodule

/* rtl/core/next_greater_element_table_unit.sv */
// ----------------------------------------------------------------------------
// next_greater_element_table_unit
// Next greater element table built on a monotonic stack in RAM.
// ----------------------------------------------------------------------------
// One transaction at a time. Push appends a value and pops every waiting
// entry whose value is smaller, recording the new value as their next
// greater element. The walk of the stack is serial: each entry compared,
// each popped entry plus the entry that stops the walk, takes a stack RAM
// read, then an element RAM read and the compare. Query scans the stored
// entries from the lowest index, one element RAM read and one compare per
// cycle. Clear, unused codes and a push into a full table go from decode
// straight to the final state. The shared compare unit serves both the pop
// test and the query match. A result sits in an output register while the
// next transaction is taken. A stalled response holds the block in its
// final state, and with it the next transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module next_greater_element_table_unit
   import ngt_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // [31:0] value
   input  logic [1:0]         req_tuser,   // [1:0] op
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [31:0] greater_value
   output logic [1:0]         rsp_tuser    // [1:0] status
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

   ngt_state_type state_ff, state_in;

   // control state
   logic [CNT_W-1:0]    count_ff, count_in;     // stored elements
   logic [CNT_W-1:0]    depth_ff, depth_in;     // waiting entries on stack
   logic [CNT_W-1:0]    scan_ff, scan_in;       // next query address
   logic                cmp_vld_ff, cmp_vld_in; // element read in flight
   logic                rsp_valid_ff, rsp_valid_in;

   // payload
   logic [OP_W-1:0]     op_ff, op_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [VALUE_W-1:0]  res_val_ff, res_val_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic [VALUE_W-1:0]  rsp_val_ff, rsp_val_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   // RAM ports
   logic               elem_we, elem_re;
   logic [IDX_W-1:0]   elem_wa, elem_ra;
   logic [VALUE_W-1:0] elem_rd;
   logic               grt_we, grt_re;
   logic [IDX_W-1:0]   grt_wa;
   logic [VALUE_W:0]   grt_wd, grt_rd;   // {has_greater, greater_value}
   logic               stk_we, stk_re;
   logic [IDX_W-1:0]   stk_wa, stk_ra;
   logic [IDX_W-1:0]   stk_wd, stk_rd;

   ngt_cmp_type        cmp;

   logic               req_fire;
   logic               rsp_free;
   logic               scan_issue;
   logic [CNT_W-1:0]   depth_dec;
   logic [CNT_W-1:0]   depth_dec2;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign scan_issue = scan_ff < count_ff;
   assign depth_dec  = depth_ff - CNT_W'(1);
   assign depth_dec2 = depth_dec - CNT_W'(1);

   // ---------------------------------------------------------------- memories
   ngt_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_wa),
      .wr_data (value_ff),
      .rd_en   (elem_re),
      .rd_addr (elem_ra),
      .rd_data (elem_rd)
   );

   ngt_ram #(.WIDTH(VALUE_W + 1), .DEPTH(MAX_ELEMENTS)) u_grt_ram (
      .clock   (clock),
      .wr_en   (grt_we),
      .wr_addr (grt_wa),
      .wr_data (grt_wd),
      .rd_en   (grt_re),
      .rd_addr (cmp_idx_ff),
      .rd_data (grt_rd)
   );

   ngt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // one compare unit for pop test and query match
   ngt_cmp u_cmp (
      .a      (elem_rd),
      .b      (value_ff),
      .result (cmp)
   );

   // -------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority if (op_ff == OP_PUSH) begin
               if (count_ff == CNT_MAX)  state_in = S_DONE;
               else if (depth_ff == '0)  state_in = S_P_FIN;
               else                      state_in = S_P_STK;
            end else if (op_ff == OP_QUERY) begin
               state_in = S_Q_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_P_STK:  state_in = S_P_ELEM;
         S_P_ELEM: begin
            if (!cmp.lt)               state_in = S_P_FIN;
            else if (depth_dec == '0)  state_in = S_P_FIN;
            else                       state_in = S_P_STK;
         end
         S_P_FIN:  state_in = S_DONE;
         S_Q_SCAN: begin
            if (cmp_vld_ff && cmp.eq) state_in = S_Q_GRD;
            else if (!scan_issue)     state_in = S_DONE;
         end
         S_Q_GRD:  state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------ datapath / outputs
   always_comb begin
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      depth_in     = depth_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;

      elem_we = 1'b0;
      elem_wa = count_ff[IDX_W-1:0];
      elem_re = 1'b0;
      elem_ra = scan_ff[IDX_W-1:0];
      grt_we  = 1'b0;
      grt_wa  = stk_rd;
      grt_wd  = {1'b1, value_ff};
      grt_re  = 1'b0;
      stk_we  = 1'b0;
      stk_wa  = depth_ff[IDX_W-1:0];
      stk_wd  = count_ff[IDX_W-1:0];
      stk_re  = 1'b0;
      stk_ra  = depth_dec[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser;
               value_in = req_tdata;
            end
         end
         S_DECODE: begin
            res_val_in = '0;
            res_st_in  = ST_OK;
            scan_in    = '0;
            priority if (op_ff == OP_CLEAR) begin
               count_in = '0;
               depth_in = '0;
            end else if (op_ff == OP_PUSH) begin
               if (count_ff == CNT_MAX) begin
                  res_st_in = ST_FULL;
               end else if (depth_ff != '0) begin
                  stk_re = 1'b1;   // top of stack
               end
            end else begin
               res_st_in = ST_OK;
            end
         end
         S_P_STK: begin
            elem_re = 1'b1;
            elem_ra = stk_rd;
         end
         S_P_ELEM: begin
            if (cmp.lt) begin
               // pop: the new value is this entry's next greater element
               grt_we   = 1'b1;
               depth_in = depth_dec;
               if (depth_dec != '0) begin
                  stk_re = 1'b1;
                  stk_ra = depth_dec2[IDX_W-1:0];
               end
            end
         end
         S_P_FIN: begin
            elem_we  = 1'b1;
            grt_we   = 1'b1;
            grt_wa   = count_ff[IDX_W-1:0];
            grt_wd   = '0;
            stk_we   = 1'b1;
            depth_in = depth_ff + CNT_W'(1);
            count_in = count_ff + CNT_W'(1);
         end
         S_Q_SCAN: begin
            if (cmp_vld_ff && cmp.eq) begin
               grt_re = 1'b1;   // first match wins
            end else if (!scan_issue) begin
               res_st_in = ST_NOT_FOUND;
            end else begin
               elem_re    = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end
         S_Q_GRD: begin
            res_val_in = grt_rd[VALUE_W] ? grt_rd[VALUE_W-1:0] : NONE_VALUE;
            res_st_in  = ST_OK;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // -------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         depth_ff     <= '0;
         scan_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         scan_ff      <= scan_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      cmp_idx_ff <= cmp_idx_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_st_ff;

   // -------------------------------------------------------------- assertions
   `ASSERT_SAME(a_depth_le_count, clock, reset, 1'b1, depth_ff <= count_ff,
      "stack deeper than element count")
   `ASSERT_SAME(a_count_le_max, clock, reset, 1'b1, count_ff <= CNT_MAX,
      "element count beyond table size")
   `ASSERT_NEXT(a_fin_grows, clock, reset, state_ff == S_P_FIN,
      count_ff == $past(count_ff) + CNT_W'(1),
      "push finish did not append an element")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, !req_tready,
      "ready held after accepting a transaction")

endmodule

/* dv/next_greater_element_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_greater_element_table_unit_tb
// Self-checking bench for the next greater element table.
// ----------------------------------------------------------------------------
// Stimulus runs in two parts. A short table of directed transactions comes
// first: the empty table after reset, the signed extremes, duplicates,
// equal values, the unused op code and clear. Random sequences follow. Each
// one opens with a clear, then mixes pushes with queries of stored and
// unknown values. Some sequences run long enough to fill the table and hit
// the full status. Every accepted request goes through a behavioral model
// of the table here, which yields the expected response. A monitor checks
// each response against the oldest expectation. The sender idles in bursts.
// The receiver stalls on its own pattern, with one long hold-off that backs
// the block up.
// ----------------------------------------------------------------------------
module next_greater_element_table_unit_tb
   import ngt_pkg::*;
();

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 10;
   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 850;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;
   // Bound for the slowest legal run: ~900 transactions, plus sender gaps and
   // receiver stalls, with a wide margin.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int REPORT_MAX   = 10;

   // op code the block must answer with ok and leave state alone
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [VALUE_W-1:0]  greater;
      logic [STATUS_W-1:0] status;
   } answer_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [VALUE_W-1:0]  value;
      logic                fixed;     // expected answer typed in below
      logic [VALUE_W-1:0]  greater;
      logic [STATUS_W-1:0] status;
   } directed_row_type;

   typedef enum int {
      STYLE_FULL, STYLE_POOL, STYLE_EDGE, STYLE_FALLING
   } value_style_type;
   typedef enum int {
      READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PATTERN
   } ready_mode_type;

   localparam int DIRECTED_ROWS = 25;
   // op, value, fixed, greater, status
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_QUERY,    32'h0,          1'b1, 32'h0,      ST_NOT_FOUND}, // empty after reset
      '{OP_RESERVED, VAL_NEG1,       1'b1, 32'h0,      ST_OK},
      '{OP_PUSH,     VAL_MIN,        1'b1, 32'h0,      ST_OK},
      '{OP_PUSH,     VAL_MIN,        1'b1, 32'h0,      ST_OK},        // duplicate
      '{OP_QUERY,    VAL_MIN,        1'b1, NONE_VALUE, ST_OK},        // nothing greater yet
      '{OP_PUSH,     VAL_MAX,        1'b1, 32'h0,      ST_OK},        // pops both
      '{OP_QUERY,    VAL_MIN,        1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    VAL_MAX,        1'b0, 32'h0,      ST_OK},
      '{OP_PUSH,     VAL_MAX,        1'b0, 32'h0,      ST_OK},        // equal, no pop
      '{OP_PUSH,     VAL_NEG1,       1'b0, 32'h0,      ST_OK},
      '{OP_PUSH,     32'h0,          1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    VAL_NEG1,       1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    VAL_MAX,        1'b0, 32'h0,      ST_OK},        // first of two matches
      '{OP_PUSH,     32'h1,          1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    32'h0,          1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    32'h1234_5678,  1'b1, 32'h0,      ST_NOT_FOUND},
      '{OP_CLEAR,    32'h0,          1'b1, 32'h0,      ST_OK},
      '{OP_QUERY,    VAL_MIN,        1'b1, 32'h0,      ST_NOT_FOUND}, // gone after clear
      '{OP_PUSH,     32'h5555_5555,  1'b0, 32'h0,      ST_OK},
      '{OP_PUSH,     32'hAAAA_AAAA,  1'b0, 32'h0,      ST_OK},
      '{OP_PUSH,     32'h7FFF_FFFE,  1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    32'hAAAA_AAAA,  1'b0, 32'h0,      ST_OK},
      '{OP_QUERY,    32'h5555_5555,  1'b0, 32'h0,      ST_OK},
      '{OP_RESERVED, 32'h0,          1'b1, 32'h0,      ST_OK},
      '{OP_CLEAR,    VAL_NEG1,       1'b1, 32'h0,      ST_OK}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;    // [31:0] value
   logic [1:0]          req_tuser;    // [1:0] op
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [31:0]         rsp_tdata;    // [31:0] greater_value
   logic [1:0]          rsp_tuser;    // [1:0] status

   // table model: stored sequence, recorded greater values, waiting stack
   logic [VALUE_W-1:0]  seq_value    [TABLE_DEPTH];
   logic [VALUE_W-1:0]  next_greater [TABLE_DEPTH];
   logic                greater_seen [TABLE_DEPTH];
   int                  wait_stack   [TABLE_DEPTH];
   int                  stack_cnt;
   int                  elem_cnt;

   answer_type          answer_q [$];     // responses still owed by the block
   int                  items_sent;
   int                  fail_count;
   int                  cycle_count;
   int                  hold_requests;    // bumped to ask the receiver for a hold-off
   bit                  gap_mode;
   int                  burst_left;
   logic [VALUE_W-1:0]  falling_level;

   always #HALF_PERIOD clock = ~clock;

   next_greater_element_table_unit #(
      .MAX_ELEMENTS (TABLE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Applies one transaction to the table model and returns its answer.
   function automatic answer_type table_answer(input logic [OP_W-1:0] op,
                                               input logic [VALUE_W-1:0] value);
      answer_type ans;
      int         top;
      bit         found;
      ans.greater = '0;
      ans.status  = ST_OK;
      case (op)
         OP_CLEAR: begin
            elem_cnt  = 0;
            stack_cnt = 0;
         end
         OP_PUSH: begin
            if (elem_cnt >= TABLE_DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               // pop every waiting entry strictly smaller than the new value
               while (stack_cnt > 0) begin
                  top = wait_stack[stack_cnt-1];
                  if (!($signed(seq_value[top]) < $signed(value))) break;
                  next_greater[top] = value;
                  greater_seen[top] = 1'b1;
                  stack_cnt--;
               end
               seq_value[elem_cnt]    = value;
               next_greater[elem_cnt] = '0;
               greater_seen[elem_cnt] = 1'b0;
               wait_stack[stack_cnt]  = elem_cnt;
               stack_cnt++;
               elem_cnt++;
            end
         end
         OP_QUERY: begin
            found      = 1'b0;
            ans.status = ST_NOT_FOUND;
            for (int i = 0; i < elem_cnt; i++) begin
               if (!found && seq_value[i] == value) begin
                  found       = 1'b1;
                  ans.status  = ST_OK;
                  ans.greater = greater_seen[i] ? next_greater[i] : NONE_VALUE;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input value_style_type style);
      logic [VALUE_W-1:0] v;
      case (style)
         STYLE_POOL:
            // tiny signed pool: plenty of duplicates and equal compares
            v = $urandom_range(0, 15) - 8;
         STYLE_EDGE: begin
            case ($urandom_range(0, 7))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = VAL_NEG1;
               3: v = 32'h0;
               4: v = 32'h1;
               5: v = VAL_MIN + 1;
               6: v = VAL_MAX - 1;
               default: v = $urandom;
            endcase
         end
         STYLE_FALLING: begin
            // mostly descending so the stack runs deep, now and then a spike
            if ($urandom_range(0, 9) == 0) begin
               v = $urandom;
            end else begin
               falling_level = falling_level - $urandom_range(0, 3);
               v = falling_level;
            end
         end
         default:
            v = $urandom;
      endcase
      return v;
   endfunction

   // Offers one transaction, starting and ending at a falling edge.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic fixed, input answer_type fixed_ans);
      answer_type ans;
      if (gap_mode) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      ans = table_answer(op, value);
      if (fixed) ans = fixed_ans;
      answer_q = {answer_q, ans};
      items_sent++;
      @(negedge clock);
   endtask

   // Stops offering until every owed response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (answer_q.size() != 0);
   endtask

   task automatic query_some(input value_style_type style);
      if (elem_cnt > 0 && $urandom_range(0, 3) != 0)
         send_item(OP_QUERY, seq_value[$urandom_range(0, elem_cnt - 1)], 1'b0, '0);
      else
         send_item(OP_QUERY, pick_value(style), 1'b0, '0);
   endtask

   // One well-formed run: clear, then pushes interleaved with queries.
   task automatic run_sequence(input int pushes, input value_style_type style);
      int done;
      int roll;
      done = 0;
      falling_level = $urandom;
      send_item(OP_CLEAR, $urandom, 1'b0, '0);
      while (done < pushes) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            send_item(OP_PUSH, pick_value(style), 1'b0, '0);
            done++;
         end else if (roll < 80) begin
            query_some(style);
         end else if (roll < 93) begin
            send_item(OP_QUERY, pick_value(style), 1'b0, '0);
         end else if (roll < 98) begin
            send_item(OP_RESERVED, $urandom, 1'b0, '0);
         end else begin
            send_item(OP_CLEAR, $urandom, 1'b0, '0);
         end
      end
      repeat ($urandom_range(0, 4)) query_some(style);
   endtask

   // Receiver: own stall pattern, with the mode redrawn at random when its run
   // ends; a hold-off request parks tready low until the hold-off has run out.
   initial begin : receiver
      ready_mode_type rdy_mode;
      int             rdy_left;
      int             hold_left;
      int             hold_served;
      logic [7:0]     rdy_pattern;
      rdy_mode    = READY_ALWAYS;
      rdy_left    = 0;
      hold_left   = 0;
      hold_served = 0;
      rdy_pattern = 8'h5A;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rdy_left == 0) begin
               rdy_mode    = ready_mode_type'($urandom_range(0, 3));
               rdy_left    = $urandom_range(50, 300);
               rdy_pattern = 8'($urandom_range(1, 255));
            end
            rdy_left--;
            case (rdy_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 9) < 7);
               READY_SELDOM: rsp_tready <= ($urandom_range(0, 9) < 3);
               default: begin
                  rsp_tready <= rdy_pattern[0];
                  rdy_pattern = {rdy_pattern[0], rdy_pattern[7:1]};
               end
            endcase
         end
      end
   end

   // Response checker: oldest expectation first.
   always @(posedge clock) begin : response_check
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected response: greater %h status %0d",
                        rsp_tdata, rsp_tuser);
         end else begin
            want = answer_q.pop_front();
            if (rsp_tdata !== want.greater || rsp_tuser !== want.status) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("mismatch: greater exp %h got %h, status exp %0d got %0d",
                           want.greater, rsp_tdata, want.status, rsp_tuser);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int seq_no;
      answer_type row_ans;
      cycle_count   = 0;
      fail_count    = 0;
      items_sent    = 0;
      hold_requests = 0;
      gap_mode      = 1'b1;
      burst_left    = 0;
      stack_cnt     = 0;
      elem_cnt      = 0;
      falling_level = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_CLEAR;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row_ans.greater = directed_rows[r].greater;
         row_ans.status  = directed_rows[r].status;
         send_item(directed_rows[r].op, directed_rows[r].value,
                   directed_rows[r].fixed, row_ans);
      end

      // random sequences
      seq_no = 0;
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         gap_mode = ($urandom_range(0, 3) != 0);
         if (seq_no == 0) begin
            // start with a full table: deep stack, then full pushes
            run_sequence(70, STYLE_FALLING);
         end else if (seq_no == 3) begin
            // long receiver hold-off while requests keep coming back to back
            gap_mode = 1'b0;
            hold_requests++;
            run_sequence(20, STYLE_FULL);
         end else if (seq_no == 6) begin
            wait_drained();
            run_sequence($urandom_range(1, 24), STYLE_POOL);
         end else if ($urandom_range(0, 4) == 0) begin
            run_sequence($urandom_range(62, 72),
                         value_style_type'($urandom_range(0, 3)));
         end else begin
            run_sequence($urandom_range(1, 24),
                         value_style_type'($urandom_range(0, 3)));
         end
         seq_no++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
